[rtl/stun_pkg.sv]
// ----------------------------------------------------------------------------
// STUN parser package
// Shared widths, codes, queue entry type and the magic cookie lookup.
// ----------------------------------------------------------------------------
package stun_pkg;

  localparam int MAX_PACKET_BYTES = 2048;
  // byte counter holds 0 .. MAX_PACKET_BYTES
  localparam int CNT_W            = $clog2(MAX_PACKET_BYTES + 1);
  localparam int HDR_BYTES        = 20;

  localparam int OFF_W            = 12;
  localparam int ULEN_W           = 11;

  localparam logic [7:0]  COLON_CHAR    = 8'h3A;
  localparam logic [15:0] A_USERNAME    = 16'h0006;
  localparam logic [15:0] A_INTEGRITY   = 16'h0008;
  localparam logic [15:0] A_PRIORITY    = 16'h0024;
  localparam logic [15:0] A_USE_CAND    = 16'h0025;
  localparam logic [15:0] A_FINGERPRINT = 16'h8028;
  localparam logic [15:0] A_CONTROLLED  = 16'h8029;
  localparam logic [15:0] A_CONTROLLING = 16'h802A;

  localparam logic [15:0] PRIO_LEN      = 16'd4;
  localparam logic [15:0] INTEG_LEN     = 16'd20;
  localparam logic [15:0] FPRINT_LEN    = 16'd4;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [2:0] {
    ST_OK,
    ST_NOT_STUN,
    ST_LEN_FIELD,
    ST_PRIO_LEN,
    ST_INTEG_LEN,
    ST_FPRINT_LEN,
    ST_OVERRUN,
    ST_TOO_LONG
  } status_t;

  // one classified byte on its way from front to back
  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic             too_long;
    logic [CNT_W-1:0] pos;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // magic cookie 0x2112A442, header bytes 4..7
  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h21;
      2'd1:    b = 8'h12;
      2'd2:    b = 8'hA4;
      default: b = 8'h42;
    endcase
    return b;
  endfunction

endpackage

[rtl/stun_if.sv]
// ----------------------------------------------------------------------------
// STUN parser channels
// Byte request channel and result request channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface stun_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface stun_result_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic [15:0]                 message_type;
  logic [31:0]                 txid_high;
  logic [63:0]                 txid_low;
  logic                        use_candidate;
  logic                        ice_controlled;
  logic                        ice_controlling;
  logic [stun_pkg::OFF_W-1:0]  username_offset;
  logic [stun_pkg::ULEN_W-1:0] username_length;
  logic                        colon_found;
  logic [stun_pkg::ULEN_W-1:0] colon_position;

  modport source (output valid, output status, output message_type, output txid_high,
                  output txid_low, output use_candidate, output ice_controlled,
                  output ice_controlling, output username_offset,
                  output username_length, output colon_found, output colon_position,
                  input ready);
  modport sink   (input valid, input status, input message_type, input txid_high,
                  input txid_low, input use_candidate, input ice_controlled,
                  input ice_controlling, input username_offset,
                  input username_length, input colon_found, input colon_position,
                  output ready);
endinterface

[rtl/stun_front.sv]
// ----------------------------------------------------------------------------
// STUN parser front end
// Takes bytes, counts position in the packet and tags over-length bytes.
// ----------------------------------------------------------------------------
module stun_front (
  input  logic              clk,
  input  logic              rst_n,
  stun_byte_if.sink         in_if,
  input  stun_pkg::q_stat_t q_stat,
  output logic              push,
  output stun_pkg::qent_t   push_ent
);
  import stun_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             too_long;

  assign in_if.ready = !q_stat.full;
  assign push        = in_if.valid && in_if.ready;
  // counter sticks at the limit: every further byte is over-length
  assign too_long    = (cnt_r >= CNT_W'(MAX_PACKET_BYTES));

  assign push_ent.data     = in_if.data_byte;
  assign push_ent.last     = in_if.last_byte;
  assign push_ent.too_long = too_long;
  assign push_ent.pos      = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push) begin
      if (in_if.last_byte) begin
        cnt_nxt = '0;
      end else if (!too_long) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/stun_queue.sv]
// ----------------------------------------------------------------------------
// STUN parser byte queue
// Short FIFO of classified bytes between front end and parse engine.
// ----------------------------------------------------------------------------
module stun_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  stun_pkg::qent_t   push_ent,
  input  logic              pop,
  output stun_pkg::qent_t   head,
  output stun_pkg::q_stat_t stat
);
  import stun_pkg::*;

  qent_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   cnt_r;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == (Q_AW + 1)'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full)) else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && stat.empty)) else $error("queue read while empty");
  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1)) else $error("queue count lost a push");
`endif

endmodule

[rtl/stun_back.sv]
// ----------------------------------------------------------------------------
// STUN parser engine
// Walks header/attributes one byte a cycle unless stalled; holds result reg.
// ----------------------------------------------------------------------------
module stun_back (
  input  logic              clk,
  input  logic              rst_n,
  input  stun_pkg::qent_t   head,
  input  stun_pkg::q_stat_t q_stat,
  output logic              pop,
  stun_result_if.source     out_if
);
  import stun_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_ATTR_HDR,
    PH_VALUE,
    PH_PAD
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [15:0]       type_r, type_nxt;
  logic [15:0]       hlen_r, hlen_nxt;
  logic [31:0]       txh_r, txh_nxt;
  logic [63:0]       txl_r, txl_nxt;
  logic [15:0]       atype_r, atype_nxt;
  logic [15:0]       arem_r, arem_nxt;
  logic [1:0]        pad_r, pad_nxt;
  logic [2:0]        flags_r, flags_nxt;
  status_t           err_r, err_nxt;
  logic [OFF_W-1:0]  uoff_r, uoff_nxt;
  logic [ULEN_W-1:0] ulen_r, ulen_nxt;
  logic              ucol_r, ucol_nxt;
  logic [ULEN_W-1:0] ucpos_r, ucpos_nxt;

  // result register
  logic              ov_r, ov_nxt;
  status_t           ost_r, ost_nxt;
  logic [15:0]       otype_r, otype_nxt;
  logic [31:0]       otxh_r, otxh_nxt;
  logic [63:0]       otxl_r, otxl_nxt;
  logic [2:0]        oflags_r, oflags_nxt;
  logic [OFF_W-1:0]  ouoff_r, ouoff_nxt;
  logic [ULEN_W-1:0] oulen_r, oulen_nxt;
  logic              oucol_r, oucol_nxt;
  logic [ULEN_W-1:0] oucpos_r, oucpos_nxt;

  logic out_free;

  assign out_free = !ov_r || out_if.ready;
  // a final byte waits until the result slot is free
  assign pop      = !q_stat.empty && (!head.last || out_free);

  always_comb begin
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] fin;
    logic [7:0]       b;
    logic [15:0]      len;
    status_t          st;

    pos = head.pos;
    b   = head.data;
    len = {arem_r[7:0], b};
    fin = pos + 1'b1;
    st  = ST_OK;

    phase_nxt = phase_r;
    type_nxt  = type_r;
    hlen_nxt  = hlen_r;
    txh_nxt   = txh_r;
    txl_nxt   = txl_r;
    atype_nxt = atype_r;
    arem_nxt  = arem_r;
    pad_nxt   = pad_r;
    flags_nxt = flags_r;
    err_nxt   = err_r;
    uoff_nxt  = uoff_r;
    ulen_nxt  = ulen_r;
    ucol_nxt  = ucol_r;
    ucpos_nxt = ucpos_r;

    ov_nxt     = ov_r && !out_if.ready;
    ost_nxt    = ost_r;
    otype_nxt  = otype_r;
    otxh_nxt   = otxh_r;
    otxl_nxt   = otxl_r;
    oflags_nxt = oflags_r;
    ouoff_nxt  = ouoff_r;
    oulen_nxt  = oulen_r;
    oucol_nxt  = oucol_r;
    oucpos_nxt = oucpos_r;

    if (pop && !head.too_long) begin
      if (pos < CNT_W'(HDR_BYTES)) begin
        if (pos == '0 && b[7:6] != 2'b00 && err_r == ST_OK) begin
          err_nxt = ST_NOT_STUN;
        end
        if (pos < CNT_W'(2)) begin
          type_nxt = {type_r[7:0], b};
        end else if (pos < CNT_W'(4)) begin
          hlen_nxt = {hlen_r[7:0], b};
        end else if (pos < CNT_W'(8)) begin
          if (b != cookie_byte(pos[1:0]) && err_r == ST_OK) begin
            err_nxt = ST_NOT_STUN;
          end
        end else if (pos < CNT_W'(12)) begin
          txh_nxt = {txh_r[23:0], b};
        end else begin
          txl_nxt = {txl_r[55:0], b};
        end
        if (pos == CNT_W'(HDR_BYTES - 1)) begin
          phase_nxt = PH_ATTR_HDR;
        end
      end else begin
        unique case (phase_r)
          PH_ATTR_HDR: begin
            if (!pos[1]) begin
              atype_nxt = {atype_r[7:0], b};
            end else begin
              arem_nxt = len;
              if (pos[0]) begin
                // attribute header complete: judge it
                case (atype_r)
                  A_USERNAME: begin
                    uoff_nxt  = OFF_W'(fin);
                    ulen_nxt  = len[ULEN_W-1:0];
                    ucol_nxt  = 1'b0;
                    ucpos_nxt = '0;
                  end
                  A_PRIORITY: begin
                    if (len != PRIO_LEN && err_r == ST_OK) err_nxt = ST_PRIO_LEN;
                  end
                  A_INTEGRITY: begin
                    if (len != INTEG_LEN && err_r == ST_OK) err_nxt = ST_INTEG_LEN;
                  end
                  A_FINGERPRINT: begin
                    if (len != FPRINT_LEN && err_r == ST_OK) err_nxt = ST_FPRINT_LEN;
                  end
                  A_USE_CAND:    flags_nxt = flags_r | 3'b001;
                  A_CONTROLLED:  flags_nxt = flags_r | 3'b010;
                  A_CONTROLLING: flags_nxt = flags_r | 3'b100;
                  default: ;
                endcase
                pad_nxt   = 2'd0 - len[1:0];
                phase_nxt = (len != '0) ? PH_VALUE : PH_ATTR_HDR;
              end
            end
          end
          PH_VALUE: begin
            if (atype_r == A_USERNAME && !ucol_r && b == COLON_CHAR) begin
              ucol_nxt  = 1'b1;
              ucpos_nxt = ULEN_W'(pos - CNT_W'(uoff_r));
            end
            arem_nxt = arem_r - 1'b1;
            if (arem_nxt == '0) begin
              phase_nxt = (pad_r != 2'd0) ? PH_PAD : PH_ATTR_HDR;
            end
          end
          PH_PAD: begin
            pad_nxt = pad_r - 1'b1;
            if (pad_nxt == 2'd0) begin
              phase_nxt = PH_ATTR_HDR;
            end
          end
          default: ;
        endcase
      end
    end

    if (pop && head.last) begin
      if (head.too_long) begin
        st = ST_TOO_LONG;
      end else if (fin < CNT_W'(HDR_BYTES) || err_nxt == ST_NOT_STUN) begin
        st = ST_NOT_STUN;
      end else if (hlen_nxt != 16'(fin - CNT_W'(HDR_BYTES)) || hlen_nxt[1:0] != 2'b00) begin
        st = ST_LEN_FIELD;
      end else if (err_nxt != ST_OK) begin
        st = err_nxt;
      end else if (phase_nxt != PH_ATTR_HDR || fin[1:0] != 2'b00) begin
        st = ST_OVERRUN;
      end
      ov_nxt     = 1'b1;
      ost_nxt    = st;
      otype_nxt  = type_nxt;
      otxh_nxt   = txh_nxt;
      otxl_nxt   = txl_nxt;
      oflags_nxt = flags_nxt;
      ouoff_nxt  = uoff_nxt;
      oulen_nxt  = ulen_nxt;
      oucol_nxt  = ucol_nxt;
      oucpos_nxt = ucpos_nxt;
      // fresh state for the next packet
      phase_nxt = PH_HEADER;
      type_nxt  = '0;
      hlen_nxt  = '0;
      txh_nxt   = '0;
      txl_nxt   = '0;
      atype_nxt = '0;
      arem_nxt  = '0;
      pad_nxt   = '0;
      flags_nxt = '0;
      err_nxt   = ST_OK;
      uoff_nxt  = '0;
      ulen_nxt  = '0;
      ucol_nxt  = 1'b0;
      ucpos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      type_r   <= '0;
      hlen_r   <= '0;
      txh_r    <= '0;
      txl_r    <= '0;
      atype_r  <= '0;
      arem_r   <= '0;
      pad_r    <= '0;
      flags_r  <= '0;
      err_r    <= ST_OK;
      uoff_r   <= '0;
      ulen_r   <= '0;
      ucol_r   <= 1'b0;
      ucpos_r  <= '0;
      ov_r     <= 1'b0;
      ost_r    <= ST_OK;
      otype_r  <= '0;
      otxh_r   <= '0;
      otxl_r   <= '0;
      oflags_r <= '0;
      ouoff_r  <= '0;
      oulen_r  <= '0;
      oucol_r  <= 1'b0;
      oucpos_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      type_r   <= type_nxt;
      hlen_r   <= hlen_nxt;
      txh_r    <= txh_nxt;
      txl_r    <= txl_nxt;
      atype_r  <= atype_nxt;
      arem_r   <= arem_nxt;
      pad_r    <= pad_nxt;
      flags_r  <= flags_nxt;
      err_r    <= err_nxt;
      uoff_r   <= uoff_nxt;
      ulen_r   <= ulen_nxt;
      ucol_r   <= ucol_nxt;
      ucpos_r  <= ucpos_nxt;
      ov_r     <= ov_nxt;
      ost_r    <= ost_nxt;
      otype_r  <= otype_nxt;
      otxh_r   <= otxh_nxt;
      otxl_r   <= otxl_nxt;
      oflags_r <= oflags_nxt;
      ouoff_r  <= ouoff_nxt;
      oulen_r  <= oulen_nxt;
      oucol_r  <= oucol_nxt;
      oucpos_r <= oucpos_nxt;
    end
  end

  assign out_if.valid           = ov_r;
  assign out_if.status          = ost_r;
  assign out_if.message_type    = otype_r;
  assign out_if.txid_high       = otxh_r;
  assign out_if.txid_low        = otxl_r;
  assign out_if.use_candidate   = oflags_r[0];
  assign out_if.ice_controlled  = oflags_r[1];
  assign out_if.ice_controlling = oflags_r[2];
  assign out_if.username_offset = ouoff_r;
  assign out_if.username_length = oulen_r;
  assign out_if.colon_found     = oucol_r;
  assign out_if.colon_position  = oucpos_r;

`ifndef SYNTHESIS
  a_result_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.last) |=> ov_r) else $error("final byte gave no result");
  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.last) |=> (phase_r == PH_HEADER && err_r == ST_OK && flags_r == '0))
    else $error("parse state not cleared after packet");
`endif

endmodule

[rtl/stun_message_parser.sv]
// ----------------------------------------------------------------------------
// STUN message parser
// Byte-wide STUN header and attribute checker with one result per packet.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_if    in   valid/ready    data_byte[7:0], last_byte
//  out_if   out  valid/ready    status, message_type, txid_high/low, ICE flags,
//                               username_offset/length, colon_found/position
//
//  Sustained rate is one byte per cycle while results are taken; the engine
//  updates its state once per byte and the queue counter bounds nothing below that.
//  With an empty queue, a final byte is written into the queue and then
//  sets the result register, from which out_if.valid is driven.
//  Reset: rst_n synchronous, active low; no clearing pass, ready after reset.
//  Stalls: a final byte is held at the queue head while the result register
//  is full; up to three further bytes are still taken before in_if.ready drops.
// ----------------------------------------------------------------------------
module stun_message_parser (
  input  logic          clk,
  input  logic          rst_n,
  stun_byte_if.sink     in_if,
  stun_result_if.source out_if
);
  import stun_pkg::*;

  // front end -> queue
  logic    push;
  qent_t   push_ent;
  // queue -> engine
  logic    pop;
  qent_t   head;
  q_stat_t q_stat;

  // counts bytes, marks those past the size limit
  stun_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .q_stat   (q_stat),
    .push     (push),
    .push_ent (push_ent)
  );

  // decouples byte intake from result back-pressure
  stun_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // header/attribute walk and result register
  stun_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_if (out_if)
  );

endmodule
